// ===== rtl/lfu_pkg.sv =====
package lfu_pkg;

  // field widths fixed by the interface
  localparam int KEY_W   = 17;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 18;
  localparam int STAMP_W = 32;
  localparam int CAP_W   = 5;

  // defaults for the top-level parameters
  localparam int ENTRIES_DEF     = 16;
  localparam int KEY_LIMIT_DEF   = 131071;
  localparam int COUNT_LIMIT_DEF = 200000;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // one entry as read out of the store during the scan
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [CNT_W-1:0]   cnt;
    logic [STAMP_W-1:0] stamp;
  } cand_t;

  // best eviction candidate seen so far
  typedef struct packed {
    logic               have;
    logic [CNT_W-1:0]   cnt;
    logic [STAMP_W-1:0] age;
  } best_t;

  // verdict of the compare unit for one entry
  typedef struct packed {
    logic               match;
    logic               take;
    logic [STAMP_W-1:0] age;
  } cmp_t;

endpackage

// ===== rtl/lfu_cmp.sv =====
module lfu_cmp (
  input  lfu_pkg::cand_t                    cand_i,
  input  logic [lfu_pkg::KEY_W-1:0]         key_i,
  input  logic [lfu_pkg::STAMP_W-1:0]       clock_i,
  input  lfu_pkg::best_t                    best_i,
  output lfu_pkg::cmp_t                     res_o
);
  import lfu_pkg::*;

  logic [STAMP_W-1:0] age;

  // age wraps with the access clock
  assign age = clock_i - cand_i.stamp;

  // key match against the word being looked up
  assign res_o.match = cand_i.valid && (cand_i.key == key_i);

  // lower count wins, equal count goes to the older entry, first one on a full tie
  assign res_o.take = cand_i.valid &&
                      (!best_i.have || (cand_i.cnt < best_i.cnt) ||
                       ((cand_i.cnt == best_i.cnt) && (age > best_i.age)));

  assign res_o.age = age;

endmodule

// ===== rtl/lfu_cache_lru_tiebreak.sv =====
// LFU key-value cache with LRU tie break.
//
// Command channel: drive operation_i (get or put), key_i and value_i with
// start high; the word is taken at a rising edge where start is high and
// busy is low. busy stays high while the word is worked on.
// Result channel: done_o pulses for one cycle with hit_o and read_value_o.
// The receiver cannot hold a result off; it must take it in that cycle.
// Capacity: capacity_i is written on any edge with capacity_we_i high; the user
// must write it only while the block is idle, as the block does not enforce this.
// Zero acts as one, above ENTRIES acts as ENTRIES.
// Timing: each word scans every entry once through one shared compare
// unit, one entry per cycle from the store's registered read port, then
// drains the read pipeline (ST_DRAIN) and writes back (ST_WB).
// busy is high through the scan, drain and write-back states; done_o rises
// in the same cycle that busy falls, and a new word may start in that cycle,
// so no word is taken before the previous one has been written back.
// Reset: all entries invalid, access clock and occupancy zero, capacity 16.
// No clearing pass is needed: entry contents are only read while valid.
module lfu_cache_lru_tiebreak #(
  parameter int ENTRIES     = lfu_pkg::ENTRIES_DEF,
  parameter int KEY_LIMIT   = lfu_pkg::KEY_LIMIT_DEF,
  parameter int COUNT_LIMIT = lfu_pkg::COUNT_LIMIT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic [lfu_pkg::KEY_W-1:0]    key_i,
  input  logic [lfu_pkg::DATA_W-1:0]   value_i,
  input  logic                         capacity_we_i,
  input  logic [lfu_pkg::CAP_W-1:0]    capacity_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [lfu_pkg::DATA_W-1:0]   read_value_o
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int EC_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [EC_W-1:0]  ENT_EC    = EC_W'(ENTRIES);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_LIMIT);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WB
  } state_e;

  state_e state_q;

  logic [IDX_W-1:0]   rd_idx_q;
  logic [ENTRIES-1:0] valid_q;
  logic [OCC_W-1:0]   occ_q;
  logic [STAMP_W-1:0] clock_q;
  logic [CAP_W-1:0]   cap_q;

  // latched command word
  logic               op_q;
  logic [KEY_W-1:0]   key_q;
  logic [DATA_W-1:0]  val_q;
  logic               over_q;

  // store and its registered read port
  logic [KEY_W-1:0]   key_mem   [ENTRIES];
  logic [DATA_W-1:0]  data_mem  [ENTRIES];
  logic [CNT_W-1:0]   cnt_mem   [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];

  logic               rd_valid_q;
  logic [KEY_W-1:0]   rd_key_q;
  logic [DATA_W-1:0]  rd_data_q;
  logic [CNT_W-1:0]   rd_cnt_q;
  logic [STAMP_W-1:0] rd_stamp_q;
  logic               ev_vld_q;
  logic [IDX_W-1:0]   ev_idx_q;

  // scan trackers
  logic               match_q;
  logic [IDX_W-1:0]   match_idx_q;
  logic [DATA_W-1:0]  match_data_q;
  logic [CNT_W-1:0]   match_cnt_q;
  logic               free_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic               vic_q;
  logic [IDX_W-1:0]   vic_idx_q;
  logic [CNT_W-1:0]   best_cnt_q;
  logic [STAMP_W-1:0] best_age_q;

  logic               accept;
  cand_t              cand;
  best_t              best;
  cmp_t               cmp;

  logic [EC_W-1:0]    eff_cap;
  logic               present;
  logic               insert;
  logic               evict;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_slot;
  logic [CNT_W-1:0]   wr_cnt;
  logic [DATA_W-1:0]  wr_data;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (capacity_we_i) begin
      cap_q <= capacity_i;
    end
  end

  // command word latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      key_q  <= key_i;
      val_q  <= value_i;
      over_q <= (32'(key_i) > 32'(KEY_LIMIT));
    end
  end

  // shared compare unit, one entry per cycle
  assign cand = '{valid: rd_valid_q, key: rd_key_q, cnt: rd_cnt_q, stamp: rd_stamp_q};
  assign best = '{have: vic_q, cnt: best_cnt_q, age: best_age_q};

  lfu_cmp u_cmp (
    .cand_i  (cand),
    .key_i   (key_q),
    .clock_i (clock_q),
    .best_i  (best),
    .res_o   (cmp)
  );

  // scan trackers: first match, first free slot, best victim
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
      vic_q   <= 1'b0;
    end else if (accept) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
      vic_q   <= 1'b0;
    end else if (ev_vld_q) begin
      if (!match_q && cmp.match) begin
        match_q      <= 1'b1;
        match_idx_q  <= ev_idx_q;
        match_data_q <= rd_data_q;
        match_cnt_q  <= rd_cnt_q;
      end
      if (!free_q && !rd_valid_q) begin
        free_q     <= 1'b1;
        free_idx_q <= ev_idx_q;
      end
      if (cmp.take) begin
        vic_q      <= 1'b1;
        vic_idx_q  <= ev_idx_q;
        best_cnt_q <= rd_cnt_q;
        best_age_q <= cmp.age;
      end
    end
  end

  // write-back decision
  always_comb begin
    eff_cap = EC_W'(cap_q);
    if (cap_q == '0) begin
      eff_cap = EC_W'(1);
    end else if (eff_cap > ENT_EC) begin
      eff_cap = ENT_EC;
    end
  end

  assign present = match_q && !over_q;
  assign insert  = (op_q == OP_PUT) && !match_q && !over_q;
  assign evict   = ((EC_W'(occ_q) >= eff_cap) || !free_q) && vic_q;
  assign wr_en   = (state_q == ST_WB) && (present || insert);
  assign wr_slot = present ? match_idx_q : (evict ? vic_idx_q : free_idx_q);
  assign wr_data = (op_q == OP_PUT) ? val_q : match_data_q;

  // saturating bump on a hit, fresh count on an insert
  always_comb begin
    wr_cnt = CNT_ONE;
    if (present) begin
      wr_cnt = (match_cnt_q < CNT_LIMIT) ? match_cnt_q + CNT_ONE : match_cnt_q;
    end
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_slot]   <= key_q;
      data_mem[wr_slot]  <= wr_data;
      cnt_mem[wr_slot]   <= wr_cnt;
      stamp_mem[wr_slot] <= clock_q;
    end
    rd_valid_q <= valid_q[rd_idx_q];
    rd_key_q   <= key_mem[rd_idx_q];
    rd_data_q  <= data_mem[rd_idx_q];
    rd_cnt_q   <= cnt_mem[rd_idx_q];
    rd_stamp_q <= stamp_mem[rd_idx_q];
    ev_idx_q   <= rd_idx_q;
  end

  // sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_idx_q     <= '0;
      ev_vld_q     <= 1'b0;
      valid_q      <= '0;
      occ_q        <= '0;
      clock_q      <= '0;
      done_o       <= 1'b0;
      hit_o        <= 1'b0;
      read_value_o <= '0;
    end else begin
      done_o   <= 1'b0;
      ev_vld_q <= (state_q == ST_SCAN);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            rd_idx_q <= '0;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_idx_q == LAST_IDX) begin
            state_q <= ST_DRAIN;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_WB;
        end
        ST_WB: begin
          if (wr_en) begin
            valid_q[wr_slot] <= 1'b1;
            clock_q          <= clock_q + STAMP_W'(1);
          end
          if (insert && !evict) begin
            occ_q <= occ_q + OCC_W'(1);
          end
          done_o       <= 1'b1;
          hit_o        <= present;
          read_value_o <= (present && (op_q == OP_GET)) ? match_data_q : '0;
          state_q      <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // a result only follows a write-back cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_WB))
    else $error("result strobe without write-back");

  // occupancy never passes the number of slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(ENTRIES))
    else $error("occupancy above slot count");

  // returned data only on a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (read_value_o != '0)) |-> hit_o)
    else $error("read data without hit");

  // an accepted word keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted word did not raise busy");

endmodule
